FILE: hdl/ile_pkg.sv
// ============================================================================
// Indexed list engine package
// Shared constants, request codes and transaction types for the list engine.
// ============================================================================
package ile_pkg;

    // Store geometry.
    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    // Request codes.
    localparam logic [2:0] REQ_GET    = 3'd0;
    localparam logic [2:0] REQ_SET    = 3'd1;
    localparam logic [2:0] REQ_APPEND = 3'd2;
    localparam logic [2:0] REQ_INSERT = 3'd3;
    localparam logic [2:0] REQ_REMOVE = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Request transaction.
    typedef struct packed {
        logic [2:0]         req_type;
        logic [9:0]         position;
        logic signed [31:0] new_value;
    } t_req;

    // Result transaction.
    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [10:0]        count;
    } t_rsp;

    // Store access command from the sequencer.
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } t_ram_cmd;

endpackage

FILE: hdl/ile_store.sv
// ============================================================================
// List entry store
// Single-clock memory with one write and one read port; read data registered.
// ============================================================================
module ile_store (
    input  logic               i_clk,
    input  ile_pkg::t_ram_cmd  i_cmd,
    output logic [ile_pkg::DATA_W-1:0] o_rdata
);

    logic [ile_pkg::DATA_W-1:0] r_mem [ile_pkg::CAPACITY];
    logic [ile_pkg::DATA_W-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        r_rdata <= r_mem[i_cmd.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/ile_seq.sv
// ============================================================================
// List sequencer
// Decodes requests, keeps the entry count and moves entries one per cycle.
// ============================================================================
module ile_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  ile_pkg::t_req      i_req,
    output ile_pkg::t_ram_cmd  o_ram,
    input  logic [ile_pkg::DATA_W-1:0] i_rdata,
    output logic               o_res_valid,
    output ile_pkg::t_rsp      o_res,
    input  logic               i_res_take
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_UP,
        S_DN,
        S_RESP
    } t_state;

    t_state r_state, n_state;
    logic [ile_pkg::CNT_W-1:0]  r_count, n_count;
    logic [ile_pkg::IDX_W-1:0]  r_pos, n_pos;
    logic [ile_pkg::IDX_W-1:0]  r_wr_addr, n_wr_addr;
    logic [ile_pkg::DATA_W-1:0] r_val, n_val;
    logic [ile_pkg::DATA_W-1:0] r_rd, n_rd;
    logic [1:0]                 r_status, n_status;
    logic                       r_remove, n_remove;
    logic                       in_range;
    logic                       full;

    assign in_range = ile_pkg::CNT_W'(i_req.position) < r_count;
    assign full     = r_count >= ile_pkg::CNT_W'(ile_pkg::CAPACITY);
    assign o_stall  = (r_state != S_IDLE);

    // Next-state logic and store commands.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_wr_addr = r_wr_addr;
        n_val     = r_val;
        n_rd      = r_rd;
        n_status  = r_status;
        n_remove  = r_remove;
        o_ram.we    = 1'b0;
        o_ram.waddr = r_wr_addr;
        o_ram.wdata = i_rdata;
        o_ram.raddr = r_wr_addr;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_pos    = i_req.position;
                    n_val    = i_req.new_value;
                    n_rd     = '0;
                    n_status = ile_pkg::ST_OK;
                    n_remove = 1'b0;
                    n_state  = S_RESP;
                    case (i_req.req_type)
                        ile_pkg::REQ_GET: begin
                            if (in_range) begin
                                o_ram.raddr = i_req.position;
                                n_state     = S_RD;
                            end else begin
                                n_status = ile_pkg::ST_RANGE;
                            end
                        end
                        ile_pkg::REQ_SET: begin
                            if (in_range) begin
                                o_ram.we    = 1'b1;
                                o_ram.waddr = i_req.position;
                                o_ram.wdata = i_req.new_value;
                            end else begin
                                n_status = ile_pkg::ST_RANGE;
                            end
                        end
                        ile_pkg::REQ_APPEND: begin
                            if (full) begin
                                n_status = ile_pkg::ST_FULL;
                            end else begin
                                o_ram.we    = 1'b1;
                                o_ram.waddr = r_count[ile_pkg::IDX_W-1:0];
                                o_ram.wdata = i_req.new_value;
                                n_count     = r_count + 1'b1;
                            end
                        end
                        ile_pkg::REQ_INSERT: begin
                            if (!in_range) begin
                                n_status = ile_pkg::ST_RANGE;
                            end else if (full) begin
                                n_status = ile_pkg::ST_FULL;
                            end else begin
                                // Start moving from the top entry downwards.
                                o_ram.raddr = ile_pkg::IDX_W'(r_count - 1'b1);
                                n_wr_addr   = r_count[ile_pkg::IDX_W-1:0];
                                n_state     = S_UP;
                            end
                        end
                        ile_pkg::REQ_REMOVE: begin
                            if (in_range) begin
                                o_ram.raddr = i_req.position;
                                n_remove    = 1'b1;
                                n_state     = S_RD;
                            end else begin
                                n_status = ile_pkg::ST_RANGE;
                            end
                        end
                        default: begin
                            n_status = ile_pkg::ST_OK;
                        end
                    endcase
                end
            end

            S_RD: begin
                // The addressed entry is now on the read port.
                n_rd = i_rdata;
                if (!r_remove) begin
                    n_state = S_RESP;
                end else begin
                    o_ram.raddr = r_pos + 1'b1;
                    n_wr_addr   = r_pos;
                    if (ile_pkg::CNT_W'(r_pos) + 1'b1 == r_count) begin
                        n_count = r_count - 1'b1;
                        n_state = S_RESP;
                    end else begin
                        n_state = S_DN;
                    end
                end
            end

            S_DN: begin
                // Pull the next entry down by one place.
                o_ram.we    = 1'b1;
                o_ram.raddr = r_wr_addr + ile_pkg::IDX_W'(2);
                n_wr_addr   = r_wr_addr + 1'b1;
                if (ile_pkg::CNT_W'(r_wr_addr) + ile_pkg::CNT_W'(2) == r_count) begin
                    n_count = r_count - 1'b1;
                    n_state = S_RESP;
                end
            end

            S_UP: begin
                // Push entries up by one place; the new value lands last.
                o_ram.we    = 1'b1;
                o_ram.raddr = r_wr_addr - ile_pkg::IDX_W'(2);
                n_wr_addr   = r_wr_addr - 1'b1;
                if (r_wr_addr == r_pos) begin
                    o_ram.wdata = r_val;
                    n_count     = r_count + 1'b1;
                    n_state     = S_RESP;
                end
            end

            S_RESP: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, count and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_pos     <= n_pos;
        r_wr_addr <= n_wr_addr;
        r_val     <= n_val;
        r_rd      <= n_rd;
        r_status  <= n_status;
        r_remove  <= n_remove;
    end

    assign o_res_valid      = (r_state == S_RESP);
    assign o_res.read_value = r_rd;
    assign o_res.status     = r_status;
    assign o_res.count      = r_count;

    // The list never holds more than the store can.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ile_pkg::CNT_W'(ile_pkg::CAPACITY))
        else $error("entry count beyond capacity");

    // The count moves by at most one per cycle.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count == $past(r_count) || r_count == $past(r_count) + 1'b1 ||
                  r_count == $past(r_count) - 1'b1))
        else $error("entry count jumped");

    // Shifting up never writes below the insert position.
    a_up_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UP |-> r_wr_addr >= r_pos)
        else $error("insert shift passed its position");

    // Shifting down stays inside the held entries.
    a_dn_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DN |-> ile_pkg::CNT_W'(r_wr_addr) + 1'b1 < r_count)
        else $error("remove shift beyond the list");

endmodule

FILE: hdl/indexed_list_engine_unit.sv
// ============================================================================
// Indexed list engine
// Ordered list of signed 32-bit words with get, set, append, insert, remove.
// ============================================================================
// One request transaction at a time. Set, append, rejected requests and unknown
// codes go straight to the result; get reads the entry first; remove reads it and
// then pulls the later entries down, and insert pushes entries up from the top down
// to its position. The entry store, with one read and one write port, moves one
// entry per cycle during a shift.
// A finished result waits in the output register, so the next request can be
// accepted while it is still stalled. The store needs no clearing after reset.
module indexed_list_engine_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  ile_pkg::t_req  i_req,
    output logic           o_valid,
    input  logic           i_stall,
    output ile_pkg::t_rsp  o_rsp
);

    ile_pkg::t_ram_cmd          ram_cmd;
    logic [ile_pkg::DATA_W-1:0] ram_rdata;
    logic                       res_valid;
    ile_pkg::t_rsp              res;
    logic                       res_take;
    logic                       r_out_valid;
    ile_pkg::t_rsp              r_out;

    ile_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req       (i_req),
        .o_ram       (ram_cmd),
        .i_rdata     (ram_rdata),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    ile_store u_store (
        .i_clk   (i_clk),
        .i_cmd   (ram_cmd),
        .o_rdata (ram_rdata)
    );

    // A result moves out when the output register is empty or draining.
    assign res_take = res_valid && (!r_out_valid || !i_stall);

    // Output register for the result transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule

FILE: tb/indexed_list_engine_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Indexed list engine testbench
// Sends get, set, append, insert and remove request transactions through the
// valid/stall handshake and checks every result transaction in order against
// a shadow copy of the list. A short table of directed requests comes first,
// then random traffic under three idling patterns.
// ============================================================================
module indexed_list_engine_unit_tb;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int DRAIN_CYCLES  = 64;
    localparam int RAND_ITEMS    = 158;
    localparam int SMALL_LEN_CAP = 40;

    // Request codes that the block treats as no operation.
    localparam logic [2:0] REQ_UNDEF_LO  = 3'd5;
    localparam logic [2:0] REQ_UNDEF_MID = 3'd6;
    localparam logic [2:0] REQ_UNDEF_HI  = 3'd7;

    // Word values at the edges of the signed and unsigned ranges.
    localparam logic [31:0] VAL_MAX  = 32'h7fff_ffff;
    localparam logic [31:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [31:0] VAL_ZERO = 32'h0000_0000;
    localparam logic [31:0] VAL_ONES = 32'hffff_ffff;

    // One row of the directed table; typed rows carry their own expectation.
    typedef struct {
        ile_pkg::t_req req;
        bit            typed;
        ile_pkg::t_rsp rsp;
    } t_dir_row;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          i_stall = 1'b0;
    ile_pkg::t_req i_req   = '0;
    logic          o_stall;
    logic          o_valid;
    ile_pkg::t_rsp o_rsp;

    // Shadow copy of the list and the results still owed by the block.
    logic [31:0]   list_words [ile_pkg::CAPACITY];
    int unsigned   list_len = 0;
    ile_pkg::t_rsp owed_rsp [$];

    int unsigned send_idle_pct  = 37;
    int unsigned recv_stall_pct = 60;
    int unsigned cycle_cnt      = 0;
    bit          run_failed     = 1'b0;

    indexed_list_engine_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    // Free-running clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic ile_pkg::t_req list_req(input logic [2:0] kind,
                                               input int unsigned pos,
                                               input logic [31:0] val);
        ile_pkg::t_req r;
        r.req_type  = kind;
        r.position  = pos[9:0];
        r.new_value = val;
        return r;
    endfunction

    function automatic t_dir_row dir_row(input ile_pkg::t_req r, input bit typed = 1'b0,
                                         input logic [31:0] rv = VAL_ZERO,
                                         input logic [1:0] st = ile_pkg::ST_OK,
                                         input int unsigned cnt = 0);
        t_dir_row row;
        row.req            = r;
        row.typed          = typed;
        row.rsp.read_value = rv;
        row.rsp.status     = st;
        row.rsp.count      = cnt[10:0];
        return row;
    endfunction

    // Applies one request to the shadow list and returns the result it gives.
    function automatic ile_pkg::t_rsp apply_list_req(input ile_pkg::t_req r);
        ile_pkg::t_rsp rsp;
        int unsigned   pos;
        int unsigned   k;
        bit            in_range;
        rsp      = '0;
        pos      = 32'(r.position);
        in_range = pos < list_len;
        case (r.req_type)
            ile_pkg::REQ_GET: begin
                if (in_range) rsp.read_value = list_words[pos];
                else rsp.status = ile_pkg::ST_RANGE;
            end
            ile_pkg::REQ_SET: begin
                if (in_range) list_words[pos] = r.new_value;
                else rsp.status = ile_pkg::ST_RANGE;
            end
            ile_pkg::REQ_APPEND: begin
                if (list_len >= ile_pkg::CAPACITY) begin
                    rsp.status = ile_pkg::ST_FULL;
                end else begin
                    list_words[list_len] = r.new_value;
                    list_len++;
                end
            end
            ile_pkg::REQ_INSERT: begin
                // The range check takes precedence over the full check.
                if (!in_range) begin
                    rsp.status = ile_pkg::ST_RANGE;
                end else if (list_len >= ile_pkg::CAPACITY) begin
                    rsp.status = ile_pkg::ST_FULL;
                end else begin
                    for (k = list_len; k > pos; k--) list_words[k] = list_words[k - 1];
                    list_words[pos] = r.new_value;
                    list_len++;
                end
            end
            ile_pkg::REQ_REMOVE: begin
                if (!in_range) begin
                    rsp.status = ile_pkg::ST_RANGE;
                end else begin
                    rsp.read_value = list_words[pos];
                    for (k = pos; k + 1 < list_len; k++) list_words[k] = list_words[k + 1];
                    list_len--;
                end
            end
            default: begin
            end
        endcase
        rsp.count = list_len[10:0];
        return rsp;
    endfunction

    // Random request, mostly in range, shrinking the list once it reaches len_cap.
    function automatic ile_pkg::t_req pick_list_req(input int unsigned len_cap);
        ile_pkg::t_req r;
        int unsigned   sel;
        sel = $urandom_range(99);
        if (sel < 5) r.req_type = 3'($urandom_range(REQ_UNDEF_HI, REQ_UNDEF_LO));
        else if (sel < 25) r.req_type = ile_pkg::REQ_GET;
        else if (sel < 40) r.req_type = ile_pkg::REQ_SET;
        else if (sel < 62) r.req_type = ile_pkg::REQ_APPEND;
        else if (sel < 82) r.req_type = ile_pkg::REQ_INSERT;
        else r.req_type = ile_pkg::REQ_REMOVE;
        if ((r.req_type == ile_pkg::REQ_APPEND || r.req_type == ile_pkg::REQ_INSERT) &&
            list_len >= len_cap && $urandom_range(9) < 7) begin
            r.req_type = ile_pkg::REQ_REMOVE;
        end
        if (list_len == 0 || $urandom_range(9) == 0) r.position = 10'($urandom);
        else r.position = 10'($urandom_range(list_len - 1));
        case ($urandom_range(9))
            0: r.new_value = VAL_MAX;
            1: r.new_value = VAL_MIN;
            2: r.new_value = VAL_ONES;
            3: r.new_value = VAL_ZERO;
            default: r.new_value = $urandom;
        endcase
        return r;
    endfunction

    // Offers one request transaction from a falling edge and waits until it
    // is taken; returns at the falling edge after acceptance.
    task automatic send_list_req(input ile_pkg::t_req r, input bit typed = 1'b0,
                                 input ile_pkg::t_rsp typed_rsp = '0);
        ile_pkg::t_rsp predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_stall);
        predicted = apply_list_req(r);
        owed_rsp.push_back(typed ? typed_rsp : predicted);
        @(negedge i_clk);
    endtask

    // Receiver back-pressure.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Result checking against the oldest owed result.
    always @(posedge i_clk) begin : rsp_check
        ile_pkg::t_rsp want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (owed_rsp.size() == 0) begin
                $error("result transaction with none expected: %h", o_rsp);
                run_failed = 1'b1;
            end else begin
                want = owed_rsp.pop_front();
                if (o_rsp.read_value !== want.read_value) begin
                    $error("read_value: expected %h, got %h", want.read_value,
                           o_rsp.read_value);
                    run_failed = 1'b1;
                end
                if (o_rsp.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_rsp.status);
                    run_failed = 1'b1;
                end
                if (o_rsp.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, o_rsp.count);
                    run_failed = 1'b1;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Stimulus.
    initial begin
        t_dir_row    dir_table [$];
        int unsigned phase;
        int unsigned n;

        // Empty list, edge values, no-op codes and the range boundary.
        dir_table = '{
            dir_row(list_req(ile_pkg::REQ_GET, 0, VAL_ONES),
                    1'b1, VAL_ZERO, ile_pkg::ST_RANGE, 0),
            dir_row(list_req(ile_pkg::REQ_REMOVE, 0, VAL_ZERO),
                    1'b1, VAL_ZERO, ile_pkg::ST_RANGE, 0),
            dir_row(list_req(ile_pkg::REQ_INSERT, 0, VAL_MAX),
                    1'b1, VAL_ZERO, ile_pkg::ST_RANGE, 0),
            dir_row(list_req(ile_pkg::REQ_SET, 1023, VAL_MIN),
                    1'b1, VAL_ZERO, ile_pkg::ST_RANGE, 0),
            dir_row(list_req(REQ_UNDEF_LO, 1023, VAL_ONES),
                    1'b1, VAL_ZERO, ile_pkg::ST_OK, 0),
            dir_row(list_req(ile_pkg::REQ_APPEND, 0, VAL_MAX),
                    1'b1, VAL_ZERO, ile_pkg::ST_OK, 1),
            dir_row(list_req(ile_pkg::REQ_APPEND, 1023, VAL_MIN),
                    1'b1, VAL_ZERO, ile_pkg::ST_OK, 2),
            dir_row(list_req(ile_pkg::REQ_APPEND, 0, VAL_ZERO),
                    1'b1, VAL_ZERO, ile_pkg::ST_OK, 3),
            dir_row(list_req(ile_pkg::REQ_APPEND, 0, VAL_ONES),
                    1'b1, VAL_ZERO, ile_pkg::ST_OK, 4),
            dir_row(list_req(ile_pkg::REQ_GET, 0, VAL_ZERO),
                    1'b1, VAL_MAX, ile_pkg::ST_OK, 4),
            dir_row(list_req(ile_pkg::REQ_GET, 1, VAL_ZERO),
                    1'b1, VAL_MIN, ile_pkg::ST_OK, 4),
            dir_row(list_req(ile_pkg::REQ_GET, 3, VAL_ZERO),
                    1'b1, VAL_ONES, ile_pkg::ST_OK, 4),
            dir_row(list_req(ile_pkg::REQ_GET, 4, VAL_ZERO),
                    1'b1, VAL_ZERO, ile_pkg::ST_RANGE, 4),
            dir_row(list_req(ile_pkg::REQ_INSERT, 4, VAL_MAX),
                    1'b1, VAL_ZERO, ile_pkg::ST_RANGE, 4),
            dir_row(list_req(ile_pkg::REQ_REMOVE, 1023, VAL_ZERO),
                    1'b1, VAL_ZERO, ile_pkg::ST_RANGE, 4),
            dir_row(list_req(ile_pkg::REQ_INSERT, 0, 32'h1234_5678)),
            dir_row(list_req(ile_pkg::REQ_INSERT, 4, 32'h0f0f_0f0f)),
            dir_row(list_req(ile_pkg::REQ_SET, 2, 32'h5555_aaaa)),
            dir_row(list_req(ile_pkg::REQ_GET, 2, VAL_ZERO)),
            dir_row(list_req(ile_pkg::REQ_GET, 5, VAL_ZERO)),
            dir_row(list_req(ile_pkg::REQ_REMOVE, 0, VAL_ZERO)),
            dir_row(list_req(ile_pkg::REQ_REMOVE, 4, VAL_ZERO)),
            dir_row(list_req(REQ_UNDEF_MID, 0, VAL_MAX)),
            dir_row(list_req(REQ_UNDEF_HI, 512, VAL_MIN)),
            dir_row(list_req(ile_pkg::REQ_REMOVE, 1, VAL_ONES))
        };

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_table[j]) send_list_req(dir_table[j].req, dir_table[j].typed,
                                             dir_table[j].rsp);

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 37;
                    recv_stall_pct = 60;
                end
                1: begin
                    send_idle_pct  = 60;
                    recv_stall_pct = 37;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase

            for (n = 0; n < RAND_ITEMS; n++) send_list_req(pick_list_req(SMALL_LEN_CAP));
        end

        i_valid <= 1'b0;
        while (owed_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!run_failed) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
